>>> hdl/chxy_pkg.sv
// Shared types and constants for the compass heading CORDIC core.
package chxy_pkg;

  localparam int ANGLE_W = 32;     // binary angle, 2^32 = one full turn
  localparam int HEADING_W = 16;   // heading in 1/128 degree
  localparam int OFFSET_W = 16;    // declination offset register
  localparam int ATAN_TAB_LEN = 24;

  localparam logic [HEADING_W-1:0] FULL_TURN = 16'd46080;  // 360 degrees
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'hFF83;  // -125
  localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

  // round(atan(2^-i) * 2^32 / (2*pi))
  localparam logic [ANGLE_W-1:0] ATAN_TAB [ATAN_TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Control bits that ride along with each sample through the pipeline.
  typedef struct packed {
    logic valid;
    logic zero;   // input vector was (0,0)
  } cell_ctl_t;

endpackage

>>> hdl/chxy_cell.sv
// One CORDIC vectoring micro-rotation stage of the pipeline.
module chxy_cell import chxy_pkg::*; #(
  parameter int XW = 19,
  parameter int SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  cell_ctl_t           ctl_in,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic [ANGLE_W-1:0]  z_in,
  output cell_ctl_t           ctl_out,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic [ANGLE_W-1:0]  z_out
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic [ANGLE_W-1:0]   z_next;

  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;

  always_comb begin
    if (!y_in[XW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ATAN_TAB[SHIFT];
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ATAN_TAB[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_next;
      y_out <= y_next;
      z_out <= z_next;
    end
  end

endmodule

>>> hdl/chxy_post.sv
// Angle to 1/128 degree conversion, declination add and wrap into [0,360).
module chxy_post import chxy_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  cell_ctl_t            ctl_in,
  input  logic [ANGLE_W-1:0]   z_in,
  input  logic [OFFSET_W-1:0]  offset,
  output logic                 valid_out,
  output logic [HEADING_W-1:0] heading
);

  localparam int PW = ANGLE_W + HEADING_W;
  localparam int SW = HEADING_W + 2;

  logic          prod_valid;
  logic [PW-1:0] prod;
  logic [PW-1:0] prod_next;

  logic [HEADING_W:0]    h_raw;
  logic [HEADING_W-1:0]  h;
  logic signed [SW-1:0]  sum;
  logic signed [SW-1:0]  wrapped;
  logic [HEADING_W-1:0]  heading_next;

  // zero vector forces angle 0
  assign prod_next = ctl_in.zero ? '0 : PW'(z_in) * PW'(FULL_TURN);

  // round to nearest, 360 maps to 0
  assign h_raw = (HEADING_W+1)'(prod[PW-1:ANGLE_W]) + (HEADING_W+1)'(prod[ANGLE_W-1]);
  assign h = (h_raw == (HEADING_W+1)'(FULL_TURN)) ? '0 : h_raw[HEADING_W-1:0];

  assign sum = $signed({2'b00, h}) + SW'($signed(offset));

  always_comb begin
    if (sum < 0) begin
      wrapped = sum + $signed({2'b00, FULL_TURN});
    end else if (sum >= $signed({2'b00, FULL_TURN})) begin
      wrapped = sum - $signed({2'b00, FULL_TURN});
    end else begin
      wrapped = sum;
    end
  end

  assign heading_next = wrapped[HEADING_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      valid_out  <= 1'b0;
    end else if (en) begin
      prod_valid <= ctl_in.valid;
      valid_out  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= prod_next;
      heading <= heading_next;
    end
  end

endmodule

>>> hdl/compass_heading_from_xy_core.sv
// Compass heading core top: input stage, CORDIC cell chain, post stage, output skid.
//
// Usage:
//   Slave stream (s_*) takes one magnetometer sample pair per transfer,
//   mag_x in the low SAMPLE_WIDTH bits of s_tdata, mag_y right above it.
//   Master stream (m_*) gives one heading per input, 0..46079 in 1/128
//   degree, in the order the samples came in.
//   cfg_wr_en/cfg_wr_data write the signed declination offset (1/128 deg);
//   write it only while no sample is in flight.
// Pipeline: input register, one register per cell, multiply, offset/wrap, and
//   output register, in that order from the input transfer to m_tvalid.
// Throughput: one transfer per cycle while the pipeline is not frozen; the chain
//   of micro-rotation cells is fully pipelined; every cell holds a different sample.
// Reset (rst, synchronous): all valid bits clear, offset returns to -125.
// Stall: when m_tready is low with a result waiting, the next result lands
//   in a one-entry skid register and the whole pipeline then freezes;
//   s_tready comes from that register only, so it never depends
//   combinationally on m_tready.
module compass_heading_from_xy_core import chxy_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  // slave stream: [SAMPLE_WIDTH-1:0] mag_x, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] mag_y
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,
  // master stream: [15:0] heading
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [HEADING_W-1:0]                   m_tdata,
  // declination offset register
  input  logic                                   cfg_wr_en,
  input  logic [OFFSET_W-1:0]                    cfg_wr_data
);

  localparam int XW = SAMPLE_WIDTH + 3;   // room for negation and CORDIC gain
  localparam int NST = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;

  logic [OFFSET_W-1:0] decl_offset;

  logic en;

  // input stage
  logic signed [SAMPLE_WIDTH-1:0] sx;
  logic signed [SAMPLE_WIDTH-1:0] sy;
  logic signed [XW-1:0]           sx_ext;
  logic signed [XW-1:0]           sy_ext;
  logic signed [XW-1:0]           x0_next;
  logic signed [XW-1:0]           y0_next;
  logic [ANGLE_W-1:0]             z0_next;
  cell_ctl_t                      ctl0_next;

  // chain taps
  cell_ctl_t            ctl [NST+1];
  logic signed [XW-1:0] x   [NST+1];
  logic signed [XW-1:0] y   [NST+1];
  logic [ANGLE_W-1:0]   z   [NST+1];

  logic                 p_valid;
  logic [HEADING_W-1:0] p_heading;

  logic                 skid_valid;
  logic [HEADING_W-1:0] skid_data;
  logic                 out_free;

  // Declination offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      decl_offset <= OFFSET_RESET;
    end else if (cfg_wr_en) begin
      decl_offset <= cfg_wr_data;
    end
  end

  // pipeline moves whenever the skid slot is empty
  assign en = !skid_valid;
  assign s_tready = en;

  // Pre-rotation: fold the left half-plane onto the right, start at 180 deg
  assign sx = s_tdata[SAMPLE_WIDTH-1:0];
  assign sy = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign sx_ext = XW'(sx);
  assign sy_ext = XW'(sy);

  always_comb begin
    if (sx_ext < 0) begin
      x0_next = -sx_ext;
      y0_next = -sy_ext;
      z0_next = HALF_TURN;
    end else begin
      x0_next = sx_ext;
      y0_next = sy_ext;
      z0_next = '0;
    end
    ctl0_next.valid = s_tvalid;
    ctl0_next.zero  = (sx == 0) && (sy == 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (en) begin
      ctl[0] <= ctl0_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= x0_next;
      y[0] <= y0_next;
      z[0] <= z0_next;
    end
  end

  // Micro-rotation cells, one shift amount each
  for (genvar i = 0; i < NST; i++) begin : g_cell
    chxy_cell #(
      .XW    (XW),
      .SHIFT (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl[i]),
      .x_in    (x[i]),
      .y_in    (y[i]),
      .z_in    (z[i]),
      .ctl_out (ctl[i+1]),
      .x_out   (x[i+1]),
      .y_out   (y[i+1]),
      .z_out   (z[i+1])
    );
  end

  // Angle conversion, declination offset, wrap
  chxy_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl_in    (ctl[NST]),
    .z_in      (z[NST]),
    .offset    (decl_offset),
    .valid_out (p_valid),
    .heading   (p_heading)
  );

  // Output register plus one-entry skid
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= p_valid;
      end
    end else if (p_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_tdata <= skid_valid ? skid_data : p_heading;
    end
    if (!out_free && en) begin
      skid_data <= p_heading;
    end
  end

  // skid slot only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds data while output register is empty");

  // skid fills only on a stalled output
  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled without an output stall");

  // heading always wrapped into [0,360)
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata < FULL_TURN))
    else $error("heading out of range");

  // a frozen pipeline keeps its result in place
  a_frozen_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && p_valid) |=> p_valid && $stable(p_heading))
    else $error("pipeline result changed while stalled");

endmodule
